/* src/iwt_pkg.sv */
// ----------------------------------------------------------------------------
// iwt_pkg
// Shared types and token codes for the integer-to-word-tokens block.
// ----------------------------------------------------------------------------
package iwt_pkg;

  localparam int unsigned ValueW  = 31;
  localparam int unsigned WordW   = 5;
  localparam int unsigned NDigits = 10;
  localparam int unsigned BcdW    = 4 * NDigits;
  localparam int unsigned MaxTok  = 16;

  localparam logic [WordW-1:0] TOK_ZERO     = 5'd0;
  localparam logic [WordW-1:0] TOK_TEEN     = 5'd10;
  localparam logic [WordW-1:0] TOK_TENS     = 5'd18;
  localparam logic [WordW-1:0] TOK_HUNDRED  = 5'd28;
  localparam logic [WordW-1:0] TOK_THOUSAND = 5'd29;
  localparam logic [WordW-1:0] TOK_MILLION  = 5'd30;
  localparam logic [WordW-1:0] TOK_BILLION  = 5'd31;

  typedef enum logic [4:0] {
    ST_HUND_DIG = 5'b00001,
    ST_HUND_TOK = 5'b00010,
    ST_TENS     = 5'b00100,
    ST_ONES     = 5'b01000,
    ST_SCALE    = 5'b10000
  } step_t;

  typedef struct packed {
    logic done;
  } bcd_status_t;

endpackage

/* src/iwt_bcd.sv */
// ----------------------------------------------------------------------------
// iwt_bcd
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module iwt_bcd
  import iwt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ValueW-1:0] value,
  output bcd_status_t       status,
  output logic [BcdW-1:0]   digits
);

  logic [ValueW-1:0] bin;
  logic [BcdW-1:0]   adj;
  logic [4:0]        cnt;
  logic              busy;
  logic              done;

  always_comb begin
    for (int k = 0; k < NDigits; k++) begin
      if (digits[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = digits[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = digits[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        bin    <= value;
        digits <= '0;
      end else if (busy) begin
        digits <= {adj[BcdW-2:0], bin[ValueW-1]};
        bin    <= {bin[ValueW-2:0], 1'b0};
        cnt    <= cnt + 5'd1;
        if (cnt == 5'(ValueW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done = done;

endmodule

/* src/integer_to_word_tokens_top.sv */
// ----------------------------------------------------------------------------
// integer_to_word_tokens_top
// Spells a 31-bit value as English word tokens, most significant first.
// Sequence: bit-serial BCD conversion after the accept, a handoff state,
// then the spelling steps for each digit group; tokens then leave at one
// token per cycle on the output (1 to 16 tokens), stalls permitting.
// A new value is accepted only in idle, once the last token of the
// previous value has entered the output register.
// Reset: rst (synchronous) empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module integer_to_word_tokens_top
  import iwt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              value_valid,
  output logic              value_ready,
  input  logic [ValueW-1:0] value,
  output logic              word_valid,
  input  logic              word_ready,
  output logic [WordW-1:0]  word,
  output logic              last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_FILL = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t            state;
  bcd_status_t       bcd_st;
  logic [BcdW-1:0]   digits;
  logic [3:0]        dg [NDigits];
  logic [1:0]        grp;
  step_t             step;
  logic [4:0]        cnt;
  logic [4:0]        rd;
  logic [WordW-1:0]  tokbuf [MaxTok];
  logic [3:0]        h, t, o;
  logic              wr_en;
  logic [WordW-1:0]  wr_tok;
  logic              accept;
  logic              emit_fire;
  logic              is_zero;

  assign value_ready = (state == S_IDLE);
  assign accept      = value_valid && value_ready;
  assign emit_fire   = (state == S_EMIT) && (!word_valid || word_ready);
  assign is_zero     = (digits == '0);

  iwt_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .value  (value),
    .status (bcd_st),
    .digits (digits)
  );

  for (genvar k = 0; k < NDigits; k++) begin : g_dig
    assign dg[k] = digits[4*k +: 4];
  end

  always_comb begin
    case (grp)
      2'd0: begin
        h = 4'd0;
        t = 4'd0;
        o = dg[9];
      end
      2'd1: begin
        h = dg[8];
        t = dg[7];
        o = dg[6];
      end
      2'd2: begin
        h = dg[5];
        t = dg[4];
        o = dg[3];
      end
      default: begin
        h = dg[2];
        t = dg[1];
        o = dg[0];
      end
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_tok = TOK_ZERO;
    case (step)
      ST_HUND_DIG: begin
        wr_en  = (h != 4'd0);
        wr_tok = {1'b0, h};
      end
      ST_HUND_TOK: begin
        wr_en  = (h != 4'd0);
        wr_tok = TOK_HUNDRED;
      end
      ST_TENS: begin
        if (t >= 4'd2) begin
          wr_en  = 1'b1;
          wr_tok = TOK_TENS + {1'b0, t};
        end else if (t == 4'd1) begin
          wr_en  = 1'b1;
          wr_tok = TOK_TEEN + {1'b0, o};
        end else begin
          wr_en  = (o != 4'd0);
          wr_tok = {1'b0, o};
        end
      end
      ST_ONES: begin
        wr_en  = (t >= 4'd2) && (o != 4'd0);
        wr_tok = {1'b0, o};
      end
      ST_SCALE: begin
        wr_en  = (grp != 2'd3) && ((h | t | o) != 4'd0);
        wr_tok = TOK_BILLION - {3'd0, grp};
      end
      default: begin
        wr_en  = 1'b0;
        wr_tok = TOK_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_valid <= 1'b0;
      grp        <= '0;
      step       <= ST_HUND_DIG;
      cnt        <= '0;
      rd         <= '0;
    end else begin
      if (word_valid && word_ready && !emit_fire) begin
        word_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (bcd_st.done) begin
            state <= S_FILL;
            grp   <= '0;
            step  <= ST_HUND_DIG;
            cnt   <= '0;
            rd    <= '0;
          end
        end
        S_FILL: begin
          if (is_zero) begin
            tokbuf[0] <= TOK_ZERO;
            cnt       <= 5'd1;
            state     <= S_EMIT;
          end else begin
            if (wr_en) begin
              tokbuf[cnt[3:0]] <= wr_tok;
              cnt              <= cnt + 5'd1;
            end
            if (step == ST_SCALE) begin
              step <= ST_HUND_DIG;
              grp  <= grp + 2'd1;
              if (grp == 2'd3) begin
                state <= S_EMIT;
              end
            end else begin
              case (step)
                ST_HUND_DIG: step <= ST_HUND_TOK;
                ST_HUND_TOK: step <= ST_TENS;
                ST_TENS:     step <= ST_ONES;
                ST_ONES:     step <= ST_SCALE;
                default:     step <= ST_HUND_DIG;
              endcase
            end
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            word_valid <= 1'b1;
            word       <= tokbuf[rd[3:0]];
            last       <= (rd == cnt - 5'd1);
            rd         <= rd + 5'd1;
            if (rd == cnt - 5'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
